@@ sv/teredo_header_parser_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Teredo header parser
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef TEREDO_HEADER_PARSER_TOP_DEFINES_SVH
`define TEREDO_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

`define THP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define THP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define THP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define THP_ASSERT(lbl, clk, rst_n, prop, msg)

`define THP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define THP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/thp_pkg.sv @@
// ---------------------------------------------------------------------------
// Teredo header parser package
// Request and result types, parser phases, status codes and queue sizes.
// ---------------------------------------------------------------------------
package thp_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES = 65535;
  localparam int unsigned CNT_W             = 16;

  // Queue depths must be powers of two (pointers wrap)
  localparam int unsigned FQ_DEPTH = 4;
  localparam int unsigned FQ_AW    = $clog2(FQ_DEPTH);
  localparam int unsigned FQ_CW    = $clog2(FQ_DEPTH + 1);
  localparam int unsigned OQ_DEPTH = 2;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_PAYLOAD_BYTES);

  localparam logic [CNT_W:0]  ORIGIN_LEN    = 17'd8;
  localparam logic [CNT_W:0]  AUTH_BASE_LEN = 17'd13;
  localparam logic [CNT_W:0]  IPV6_MIN_LEN  = 17'd40;
  localparam logic [CNT_W:0]  NONCE_SPAN    = 17'd9;
  localparam logic [3:0]      IPV6_NIBBLE   = 4'h6;
  localparam logic [15:0]     PORT_MASK     = 16'hFFFF;
  localparam logic [31:0]     ADDR_MASK     = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    PH_TAG_HI = 3'd0,
    PH_TAG_LO = 3'd1,
    PH_ORIGIN = 3'd2,
    PH_AUTH   = 3'd3,
    PH_IPV6   = 3'd4,
    PH_DONE   = 3'd5
  } thp_phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT_TAG    = 3'd1,
    ST_SHORT_ORIGIN = 3'd2,
    ST_SHORT_AUTH   = 3'd3,
    ST_SHORT_IPV6   = 3'd4,
    ST_MISORDER     = 3'd5,
    ST_BAD_TAG      = 3'd6
  } thp_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } thp_in_t;

  // Byte as held in the front queue, with its classification
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_zero;
    logic       is_one;
    logic       is_v6;
  } thp_fq_t;

  typedef struct packed {
    thp_status_t status;
    logic        has_auth;
    logic        has_origin;
    logic [7:0]  cid_length;
    logic [7:0]  auth_value_length;
    logic [63:0] auth_nonce;
    logic [7:0]  auth_confirmation;
    logic [15:0] origin_port;
    logic [31:0] origin_addr;
    logic [9:0]  inner_offset;
    logic [15:0] inner_length;
  } thp_out_t;

endpackage

@@ sv/thp_front.sv @@
// ---------------------------------------------------------------------------
// Teredo header parser front end
// Accepts payload bytes, classifies them for tag decoding and queues them.
// ---------------------------------------------------------------------------
`include "teredo_header_parser_top_defines.svh"

module thp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  thp_pkg::thp_in_t   in_item,
  output logic               fq_valid,
  input  logic               fq_pop,
  output thp_pkg::thp_fq_t   fq_item
);

  thp_pkg::thp_fq_t              mem_r [thp_pkg::FQ_DEPTH];
  logic [thp_pkg::FQ_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [thp_pkg::FQ_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [thp_pkg::FQ_CW-1:0]     count_r, count_nxt;
  logic                          do_push, do_pop;
  thp_pkg::thp_fq_t              cls;

  assign in_full  = (count_r == thp_pkg::FQ_CW'(thp_pkg::FQ_DEPTH));
  assign fq_valid = (count_r != '0);
  assign do_push  = in_push && !in_full;
  assign do_pop   = fq_pop && fq_valid;
  assign fq_item  = mem_r[rd_ptr_r];

  always_comb begin
    cls.data_byte = in_item.data_byte;
    cls.last_byte = in_item.last_byte;
    cls.is_zero   = (in_item.data_byte == 8'd0);
    cls.is_one    = (in_item.data_byte == 8'd1);
    cls.is_v6     = (in_item.data_byte[7:4] == thp_pkg::IPV6_NIBBLE);
  end

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  `THP_ASSERT(a_fq_bound, clk, rst_n, count_r <= thp_pkg::FQ_CW'(thp_pkg::FQ_DEPTH), "front queue overflow")
  `THP_ASSERT_NEXT(a_fq_grow, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "front queue count did not advance")

endmodule

@@ sv/thp_parse.sv @@
// ---------------------------------------------------------------------------
// Teredo header parser back end
// Walks tags one byte per cycle (oq_full stalls last bytes); forms verdicts.
// ---------------------------------------------------------------------------
`include "teredo_header_parser_top_defines.svh"

module thp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fq_valid,
  output logic               fq_pop,
  input  thp_pkg::thp_fq_t   fq_item,
  input  logic               oq_full,
  output logic               oq_push,
  output thp_pkg::thp_out_t  oq_item
);

  localparam int unsigned CW = thp_pkg::CNT_W;

  thp_pkg::thp_phase_t  phase_r, phase_nxt;
  thp_pkg::thp_status_t verdict_r, verdict_nxt;
  logic [CW-1:0]        byte_count_r, byte_count_nxt;
  logic [CW-1:0]        inner_start_r, inner_start_nxt;
  logic [CW:0]          header_end_r, header_end_nxt;
  logic                 saw_origin_r, saw_origin_nxt;
  logic                 saw_auth_r, saw_auth_nxt;
  logic                 th_zero_r, th_zero_nxt;
  logic                 th_v6_r, th_v6_nxt;
  logic [7:0]           id_length_r, id_length_nxt;
  logic [7:0]           value_length_r, value_length_nxt;
  logic [63:0]          nonce_shift_r, nonce_shift_nxt;
  logic [7:0]           confirm_byte_r, confirm_byte_nxt;
  logic [15:0]          port_reg_r, port_reg_nxt;
  logic [31:0]          addr_reg_r, addr_reg_nxt;

  logic                 take;
  logic [CW-1:0]        rel;
  logic [CW:0]          pos_p1, pos_p9;
  logic [7:0]           b;
  thp_pkg::thp_status_t status;
  logic                 ok;

  // Stall only a final byte whose result has nowhere to go
  assign take    = fq_valid && !(fq_item.last_byte && oq_full);
  assign fq_pop  = take;
  assign oq_push = take && fq_item.last_byte;

  assign b      = fq_item.data_byte;
  assign rel    = byte_count_r - inner_start_r;
  assign pos_p1 = {1'b0, byte_count_r} + 17'd1;
  assign pos_p9 = {1'b0, byte_count_r} + thp_pkg::NONCE_SPAN;

  // Next state
  always_comb begin
    phase_nxt        = phase_r;
    verdict_nxt      = verdict_r;
    byte_count_nxt   = byte_count_r;
    inner_start_nxt  = inner_start_r;
    header_end_nxt   = header_end_r;
    saw_origin_nxt   = saw_origin_r;
    saw_auth_nxt     = saw_auth_r;
    th_zero_nxt      = th_zero_r;
    th_v6_nxt        = th_v6_r;
    id_length_nxt    = id_length_r;
    value_length_nxt = value_length_r;
    nonce_shift_nxt  = nonce_shift_r;
    confirm_byte_nxt = confirm_byte_r;
    port_reg_nxt     = port_reg_r;
    addr_reg_nxt     = addr_reg_r;
    // Drop bytes past the maximum payload length
    if (byte_count_r < thp_pkg::MAX_COUNT) begin
      byte_count_nxt = byte_count_r + 1'b1;
      case (phase_r)
        thp_pkg::PH_TAG_HI: begin
          inner_start_nxt = byte_count_r;
          th_zero_nxt     = fq_item.is_zero;
          th_v6_nxt       = fq_item.is_v6;
          phase_nxt       = thp_pkg::PH_TAG_LO;
        end
        thp_pkg::PH_TAG_LO: begin
          if (th_zero_r && fq_item.is_zero) begin
            if (saw_origin_r) begin
              verdict_nxt = thp_pkg::ST_MISORDER;
              phase_nxt   = thp_pkg::PH_DONE;
            end else begin
              header_end_nxt = {1'b0, inner_start_r} + thp_pkg::ORIGIN_LEN;
              phase_nxt      = thp_pkg::PH_ORIGIN;
            end
          end else if (th_zero_r && fq_item.is_one) begin
            if (saw_origin_r || saw_auth_r) begin
              verdict_nxt = thp_pkg::ST_MISORDER;
              phase_nxt   = thp_pkg::PH_DONE;
            end else begin
              phase_nxt = thp_pkg::PH_AUTH;
            end
          end else if (th_v6_r) begin
            header_end_nxt = {1'b0, inner_start_r} + thp_pkg::IPV6_MIN_LEN;
            phase_nxt      = thp_pkg::PH_IPV6;
          end else begin
            verdict_nxt = thp_pkg::ST_BAD_TAG;
            phase_nxt   = thp_pkg::PH_DONE;
          end
        end
        thp_pkg::PH_ORIGIN: begin
          if (rel < 16'd4) begin
            port_reg_nxt = {port_reg_r[7:0], b};
          end else begin
            addr_reg_nxt = {addr_reg_r[23:0], b};
          end
          if (pos_p1 == header_end_r) begin
            saw_origin_nxt = 1'b1;
            phase_nxt      = thp_pkg::PH_TAG_HI;
          end
        end
        thp_pkg::PH_AUTH: begin
          if (rel == 16'd2) begin
            id_length_nxt = b;
          end else if (rel == 16'd3) begin
            value_length_nxt = b;
            header_end_nxt   = {1'b0, inner_start_r} + thp_pkg::AUTH_BASE_LEN
                               + {9'd0, id_length_r} + {9'd0, b};
          end else if (pos_p1 == header_end_r) begin
            confirm_byte_nxt = b;
            saw_auth_nxt     = 1'b1;
            phase_nxt        = thp_pkg::PH_TAG_HI;
          end else if (pos_p9 >= header_end_r) begin
            nonce_shift_nxt = {nonce_shift_r[55:0], b};
          end
        end
        thp_pkg::PH_IPV6: begin
          if (pos_p1 == header_end_r) begin
            verdict_nxt = thp_pkg::ST_OK;
            phase_nxt   = thp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result for the final byte
  always_comb begin
    case (phase_nxt)
      thp_pkg::PH_DONE:   status = verdict_nxt;
      thp_pkg::PH_ORIGIN: status = thp_pkg::ST_SHORT_ORIGIN;
      thp_pkg::PH_AUTH:   status = thp_pkg::ST_SHORT_AUTH;
      thp_pkg::PH_IPV6:   status = thp_pkg::ST_SHORT_IPV6;
      default:            status = thp_pkg::ST_SHORT_TAG;
    endcase
    ok = (status == thp_pkg::ST_OK);
    oq_item                   = '0;
    oq_item.status            = status;
    if (ok && saw_auth_nxt) begin
      oq_item.has_auth          = 1'b1;
      oq_item.cid_length        = id_length_nxt;
      oq_item.auth_value_length = value_length_nxt;
      oq_item.auth_nonce        = nonce_shift_nxt;
      oq_item.auth_confirmation = confirm_byte_nxt;
    end
    if (ok && saw_origin_nxt) begin
      oq_item.has_origin  = 1'b1;
      oq_item.origin_port = port_reg_nxt ^ thp_pkg::PORT_MASK;
      oq_item.origin_addr = addr_reg_nxt ^ thp_pkg::ADDR_MASK;
    end
    if (ok) begin
      oq_item.inner_offset = inner_start_nxt[9:0];
      oq_item.inner_length = byte_count_nxt - inner_start_nxt;
    end
  end

  // Control state; clear after the final byte so the next payload starts fresh
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= thp_pkg::PH_TAG_HI;
      verdict_r     <= thp_pkg::ST_OK;
      byte_count_r  <= '0;
      inner_start_r <= '0;
      header_end_r  <= '0;
      saw_origin_r  <= 1'b0;
      saw_auth_r    <= 1'b0;
      th_zero_r     <= 1'b0;
      th_v6_r       <= 1'b0;
    end else if (take) begin
      if (fq_item.last_byte) begin
        phase_r       <= thp_pkg::PH_TAG_HI;
        verdict_r     <= thp_pkg::ST_OK;
        byte_count_r  <= '0;
        inner_start_r <= '0;
        header_end_r  <= '0;
        saw_origin_r  <= 1'b0;
        saw_auth_r    <= 1'b0;
        th_zero_r     <= 1'b0;
        th_v6_r       <= 1'b0;
      end else begin
        phase_r       <= phase_nxt;
        verdict_r     <= verdict_nxt;
        byte_count_r  <= byte_count_nxt;
        inner_start_r <= inner_start_nxt;
        header_end_r  <= header_end_nxt;
        saw_origin_r  <= saw_origin_nxt;
        saw_auth_r    <= saw_auth_nxt;
        th_zero_r     <= th_zero_nxt;
        th_v6_r       <= th_v6_nxt;
      end
    end
  end

  // Extracted fields are fully rewritten before they are reported
  always_ff @(posedge clk) begin
    if (take) begin
      id_length_r    <= id_length_nxt;
      value_length_r <= value_length_nxt;
      nonce_shift_r  <= nonce_shift_nxt;
      confirm_byte_r <= confirm_byte_nxt;
      port_reg_r     <= port_reg_nxt;
      addr_reg_r     <= addr_reg_nxt;
    end
  end

  `THP_ASSERT_IMP(a_push_on_last, clk, rst_n, oq_push, fq_valid && fq_item.last_byte && !oq_full, "result pushed without a final byte or into a full queue")
  `THP_ASSERT_NEXT(a_restart, clk, rst_n, oq_push, phase_r == thp_pkg::PH_TAG_HI && byte_count_r == '0, "parser did not restart after a result")
  `THP_ASSERT_IMP(a_ok_in_done, clk, rst_n, oq_push && oq_item.status == thp_pkg::ST_OK, phase_nxt == thp_pkg::PH_DONE, "ok verdict outside the done phase")

endmodule

@@ sv/thp_outq.sv @@
// ---------------------------------------------------------------------------
// Teredo header parser result queue
// Holds finished verdicts until the consumer pops them.
// ---------------------------------------------------------------------------
module thp_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              oq_push,
  output logic              oq_full,
  input  thp_pkg::thp_out_t oq_item,
  output logic              out_empty,
  input  logic              out_pop,
  output thp_pkg::thp_out_t out_item
);

  thp_pkg::thp_out_t          mem_r [thp_pkg::OQ_DEPTH];
  logic [thp_pkg::OQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [thp_pkg::OQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [thp_pkg::OQ_CW-1:0]  count_r, count_nxt;
  logic                       do_push, do_pop;

  assign oq_full   = (count_r == thp_pkg::OQ_CW'(thp_pkg::OQ_DEPTH));
  assign out_empty = (count_r == '0);
  assign do_push   = oq_push && !oq_full;
  assign do_pop    = out_pop && !out_empty;
  assign out_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= oq_item;
    end
  end

endmodule

@@ sv/teredo_header_parser_top.sv @@
// The parser forms a verdict as it pops a final byte; the result queue holds it for out_item.
// Throughput: one payload byte per cycle unless a final byte waits on a full result queue.
// A four-entry byte queue and a two-entry result queue let each side stall on its own.
// in_full rises only when the byte queue holds four bytes, the oldest a final byte held
// back by a full result queue.
// Reset: synchronous, active low; clears both queues and the parser control state.
// ---------------------------------------------------------------------------
// Teredo header parser top level
// Byte-serial Teredo encapsulation header parser with queue interfaces.
// ---------------------------------------------------------------------------
module teredo_header_parser_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  thp_pkg::thp_in_t  in_item,
  output logic              out_empty,
  input  logic              out_pop,
  output thp_pkg::thp_out_t out_item
);

  thp_pkg::thp_fq_t   fq_item;
  logic               fq_valid;
  logic               fq_pop;
  thp_pkg::thp_out_t  oq_item;
  logic               oq_push;
  logic               oq_full;

  thp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .fq_valid (fq_valid),
    .fq_pop   (fq_pop),
    .fq_item  (fq_item)
  );

  thp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fq_valid  (fq_valid),
    .fq_pop    (fq_pop),
    .fq_item   (fq_item),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_item   (oq_item)
  );

  thp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .oq_push   (oq_push),
    .oq_full   (oq_full),
    .oq_item   (oq_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
